>>> design/wide_multiply_hash256_engine_macros.svh
// Assertion macros used by the checker file of the hash engine.
`ifndef WIDE_MULTIPLY_HASH256_ENGINE_MACROS_SVH
`define WIDE_MULTIPLY_HASH256_ENGINE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define WMH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash engine check failed");

// Consequent checked in the cycle after the antecedent.
`define WMH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash engine check failed");

`endif

>>> design/wmh_pkg.sv
// Package: types, constants, tables and bit functions of the hash engine.
package wmh_pkg;

   localparam int WORD_W      = 32;
   localparam int NUM_ROUNDS  = 52;
   localparam int MR_DEPTH    = 13;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type LOWER_KEY_MASK = 32'h5A5A5A5A;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_FIELD_FILL = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'(NUM_ROUNDS - 1);

   typedef struct packed {
      word_type a;
      word_type b;
   } mul_op_type;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_PUSH       = 12'b0000_0000_0010,
      ST_PAD_MARK   = 12'b0000_0000_0100,
      ST_PAD_ZERO   = 12'b0000_0000_1000,
      ST_PAD_LEN    = 12'b0000_0001_0000,
      ST_CMP_LOAD   = 12'b0000_0010_0000,
      ST_CMP_ROUND  = 12'b0000_0100_0000,
      ST_CMP_ADD    = 12'b0000_1000_0000,
      ST_FOLD       = 12'b0001_0000_0000,
      ST_MIX        = 12'b0010_0000_0000,
      ST_MIX_COMMIT = 12'b0100_0000_0000,
      ST_OUT        = 12'b1000_0000_0000
   } state_type;

   function automatic word_type rotr(input word_type x, input logic [4:0] n);
      return (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic word_type big_s0(input word_type x);
      return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic word_type big_s1(input word_type x);
      return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic word_type small_s0(input word_type x);
      return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic word_type small_s1(input word_type x);
      return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(input word_type x, input word_type y,
                                       input word_type z);
      return (x & y) ^ (~x & z);
   endfunction

   function automatic word_type major(input word_type x, input word_type y,
                                      input word_type z);
      return (x & y) ^ (x & z) ^ (y & z);
   endfunction

   function automatic word_type round_key(input logic [5:0] r);
      word_type k;
      unique case (r)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type iv_word(input logic [3:0] i);
      word_type v;
      unique case (i)
         4'd0:  v = 32'h6a09e667;  4'd1:  v = 32'hbb67ae85;
         4'd2:  v = 32'h3c6ef372;  4'd3:  v = 32'ha54ff53a;
         4'd4:  v = 32'h510e527f;  4'd5:  v = 32'h9b05688c;
         4'd6:  v = 32'h1f83d9ab;  4'd7:  v = 32'h5be0cd19;
         4'd8:  v = 32'hcbbb9d5d;  4'd9:  v = 32'h629a292a;
         4'd10: v = 32'h9159015a;  4'd11: v = 32'h152fecd8;
         4'd12: v = 32'h67332667;  4'd13: v = 32'h8eb44a87;
         4'd14: v = 32'hdb0c2e0d;  4'd15: v = 32'h47b5481d;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> design/wmh_chan_if.sv
// Interfaces: message word channel and digest word channel.
interface wmh_req_if import wmh_pkg::*; ;
   logic           valid;
   logic           ready;
   word_type       data_word;
   logic [2:0]     valid_bytes;
   logic           last_word;

   modport source(output valid, data_word, valid_bytes, last_word, input ready);
   modport sink(input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface wmh_rsp_if import wmh_pkg::*; ;
   logic           valid;
   logic           ready;
   word_type       digest_word;
   logic [2:0]     word_index;
   logic           last_result;

   modport source(output valid, digest_word, word_index, last_result, input ready);
   modport sink(input valid, digest_word, word_index, last_result, output ready);
endinterface

>>> design/wmh_mix_unit.sv
// Shared 32x32 multiplier: registered high-xor-low of the product.
module wmh_mix_unit import wmh_pkg::*; (
   input  logic       clock,
   input  mul_op_type mul_op,
   output word_type   mix_res
);

   logic [2*WORD_W-1:0] prod;
   word_type            res_ff;
   word_type            res_in;

   assign prod   = {{WORD_W{1'b0}}, mul_op.a} * {{WORD_W{1'b0}}, mul_op.b};
   assign res_in = prod[2*WORD_W-1:WORD_W] ^ prod[WORD_W-1:0];

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign mix_res = res_ff;

endmodule

>>> design/wide_multiply_hash256_engine.sv
// Top level: byte collection, padding, compression, fold and mix sequencer.
//
//  channel   | dir | handshake          | word
//  req_chan  | in  | valid/ready        | data_word, valid_bytes, last_word
//  rsp_chan  | out | valid/ready        | digest_word, word_index, last_result
//
// One byte enters the block buffer per cycle, except while a full block is compressed.
// A full 64-byte block is compressed in 52 rounds, each paced by the one shared
// multiplier that forms 13 products per round.
// The final word adds padding (up to two blocks), the fold and the mix, then eight
// digest words, one per accept.
// Reset is synchronous; ready is low from accept until the block is idle again.
module wide_multiply_hash256_engine import wmh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   wmh_req_if.sink      req_chan,
   wmh_rsp_if.source    rsp_chan
);

   state_type    state_ff, state_in;
   state_type    ret_ff, ret_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in;
   word_type     chain_ff [16];
   word_type     chain_in [16];
   logic [3:0]   step_ff, step_in;
   logic [5:0]   round_ff, round_in;
   logic [2:0]   qc_ff, qc_in;
   logic [1:0]   mix_rnd_ff, mix_rnd_in;
   logic [2:0]   rem_ff, rem_in;
   logic         last_ff, last_in;
   logic [2:0]   lc_ff, lc_in;
   logic [2:0]   out_idx_ff, out_idx_in;

   word_type     work_ff [16];
   word_type     work_in [16];
   word_type     blk_ff [16];
   word_type     blk_in [16];
   word_type     fw_ff [8];
   word_type     fw_in [8];
   word_type     nf_ff [8];
   word_type     nf_in [8];
   word_type     mr_ff [MR_DEPTH];
   word_type     mr_in [MR_DEPTH];
   word_type     t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in, t4_ff, t4_in;
   word_type     acc_ff, acc_in, wv_ff, wv_in, y0_ff, y0_in;
   word_type     data_ff, data_in;

   mul_op_type   mul_op;
   word_type     mix_res;
   word_type     rnd_s [16];
   word_type     rnd_m [10];
   word_type     key;
   word_type     fold_x;
   logic         push_en;
   logic [7:0]   push_byte;
   state_type    after_st;
   logic [2:0]   take_cnt;

   wmh_mix_unit u_mix (
      .clock   (clock),
      .mul_op  (mul_op),
      .mix_res (mix_res)
   );

   assign key      = round_key(round_ff);
   assign fold_x   = chain_ff[0] ^ chain_ff[8];
   assign take_cnt = (req_chan.valid_bytes > 3'd4) ? 3'd4 : req_chan.valid_bytes;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.digest_word = fw_ff[0];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_result = (out_idx_ff == 3'd7);

   // New round state before the half interleave.
   always_comb begin
      for (int k = 0; k < 10; k++) begin
         rnd_m[k] = mr_ff[k + 3];
      end
      rnd_s[0]  = t1_ff + t2_ff + y0_ff + rnd_m[8];
      rnd_s[1]  = work_ff[0] + rnd_m[5] + rnd_m[9];
      rnd_s[2]  = work_ff[1];
      rnd_s[3]  = work_ff[2] + rnd_m[1] + rnd_m[6];
      rnd_s[4]  = work_ff[3] + t1_ff + rnd_m[8];
      rnd_s[5]  = work_ff[4] + rnd_m[7];
      rnd_s[6]  = work_ff[5];
      rnd_s[7]  = work_ff[6] + rnd_m[2] + rnd_m[9];
      rnd_s[8]  = t3_ff + t4_ff + y0_ff;
      rnd_s[9]  = work_ff[8] + rnd_m[5];
      rnd_s[10] = work_ff[9];
      rnd_s[11] = work_ff[10] + rnd_m[3] + rnd_m[6];
      rnd_s[12] = work_ff[11] + t3_ff + rnd_m[8];
      rnd_s[13] = work_ff[12] + rnd_m[7];
      rnd_s[14] = work_ff[13];
      rnd_s[15] = work_ff[14] + (rnd_m[1] ^ rnd_m[2] ^ rnd_m[3]) + rnd_m[9];
   end

   // Multiplier operand select.
   always_comb begin
      mul_op = '0;
      unique case (state_ff)
         ST_CMP_ROUND: begin
            unique case (step_ff)
               4'd0: mul_op = '{blk_ff[13], blk_ff[6]};
               4'd1: mul_op = '{blk_ff[11], blk_ff[4]};
               4'd2: mul_op = '{blk_ff[15] ^ blk_ff[8], blk_ff[12] ^ blk_ff[2]};
               4'd3: mul_op = '{work_ff[0] ^ work_ff[8], work_ff[4] ^ work_ff[12]};
               4'd4: mul_op = '{work_ff[1] ^ work_ff[9], work_ff[5] ^ work_ff[13]};
               4'd5: mul_op = '{work_ff[2] ^ work_ff[10], work_ff[6] ^ work_ff[14]};
               4'd6: mul_op = '{work_ff[3] ^ work_ff[11], work_ff[7] ^ work_ff[15]};
               4'd7: mul_op = '{work_ff[0] ^ work_ff[12], work_ff[4] ^ work_ff[8]};
               4'd8: mul_op = '{work_ff[1] ^ work_ff[13], work_ff[5] ^ work_ff[9]};
               4'd9: mul_op = '{work_ff[2] ^ work_ff[14], work_ff[6] ^ work_ff[10]};
               4'd10: mul_op = '{work_ff[3] ^ work_ff[15], work_ff[7] ^ work_ff[11]};
               4'd11: mul_op = '{work_ff[0] ^ work_ff[15], work_ff[3] ^ work_ff[12]};
               4'd12: mul_op = '{work_ff[1] ^ work_ff[14], work_ff[2] ^ work_ff[13]};
               default: mul_op = '0;
            endcase
         end
         ST_FOLD: begin
            unique case (step_ff)
               4'd0: mul_op = '{chain_ff[0], rotr(chain_ff[8], 5'd19)};
               4'd1: mul_op = '{chain_ff[8], rotr(chain_ff[0], 5'd7)};
               4'd2: mul_op = '{fold_x,
                                rotr(chain_ff[0], 5'd3) ^ rotr(chain_ff[8], 5'd21)};
               default: mul_op = '0;
            endcase
         end
         ST_MIX: begin
            unique case (step_ff)
               4'd0: mul_op = '{fw_ff[1], fw_ff[5]};
               4'd1: mul_op = '{fw_ff[2], fw_ff[6]};
               default: mul_op = '0;
            endcase
         end
         default: mul_op = '0;
      endcase
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      step_in    = step_ff;
      round_in   = round_ff;
      qc_in      = qc_ff;
      mix_rnd_in = mix_rnd_ff;
      rem_in     = rem_ff;
      last_in    = last_ff;
      lc_in      = lc_ff;
      out_idx_in = out_idx_ff;
      chain_in   = chain_ff;
      work_in    = work_ff;
      blk_in     = blk_ff;
      fw_in      = fw_ff;
      nf_in      = nf_ff;
      mr_in      = mr_ff;
      t1_in      = t1_ff;
      t2_in      = t2_ff;
      t3_in      = t3_ff;
      t4_in      = t4_ff;
      acc_in     = acc_ff;
      wv_in      = wv_ff;
      y0_in      = y0_ff;
      data_in    = data_ff;
      push_en    = 1'b0;
      push_byte  = '0;
      after_st   = state_ff;

      // capture products issued in the previous cycle
      if ((state_ff == ST_CMP_ROUND || state_ff == ST_FOLD || state_ff == ST_MIX)
          && step_ff != 4'd0 && step_ff <= 4'(MR_DEPTH)) begin
         mr_in[step_ff - 4'd1] = mix_res;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               data_in  = req_chan.data_word;
               rem_in   = take_cnt;
               last_in  = req_chan.last_word;
               len_in   = len_ff + {58'd0, take_cnt, 3'd0};
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rem_ff != 3'd0) begin
               push_en   = 1'b1;
               push_byte = data_ff[31:24];
               data_in   = data_ff << 8;
               rem_in    = rem_ff - 3'd1;
               after_st  = ST_PUSH;
            end else if (last_ff) begin
               state_in = ST_PAD_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD_MARK: begin
            push_en   = 1'b1;
            push_byte = PAD_MARK_BYTE;
            lc_in     = '0;
            after_st  = ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            if (fill_ff == LEN_FIELD_FILL) begin
               state_in = ST_PAD_LEN;
            end else begin
               push_en  = 1'b1;
               after_st = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            push_en   = 1'b1;
            push_byte = len_ff[63:56];
            len_in    = len_ff << 8;
            lc_in     = lc_ff + 3'd1;
            after_st  = (lc_ff == 3'd7) ? ST_FOLD : ST_PAD_LEN;
         end
         ST_CMP_LOAD: begin
            work_in  = chain_ff;
            round_in = '0;
            step_in  = '0;
            state_in = ST_CMP_ROUND;
         end
         ST_CMP_ROUND: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd1: acc_in = small_s1(blk_ff[14]) + blk_ff[9] + small_s0(blk_ff[1])
                              + blk_ff[0];
               4'd4: wv_in = (round_ff < 6'd16) ? blk_ff[0]
                             : acc_ff + mr_ff[0] + (mr_ff[1] ^ mr_ff[2]);
               4'd5: begin
                  t1_in = work_ff[7] + big_s1(work_ff[4])
                          + choose(work_ff[4], work_ff[5], work_ff[6]);
                  t3_in = work_ff[15] + big_s1(work_ff[12])
                          + choose(work_ff[12], work_ff[13], work_ff[14]);
               end
               4'd6: begin
                  t1_in = t1_ff + key + wv_ff;
                  t3_in = t3_ff + (key ^ LOWER_KEY_MASK) + wv_ff;
                  t2_in = big_s0(work_ff[0]) + major(work_ff[0], work_ff[1], work_ff[2]);
                  t4_in = big_s0(work_ff[8]) + major(work_ff[8], work_ff[9], work_ff[10]);
               end
               4'd10: y0_in = mr_ff[3] + mr_ff[7];
               4'd14: begin
                  if (round_ff[1:0] == 2'd3) begin
                     for (int q = 0; q < 8; q++) begin
                        work_in[2*q]     = rnd_s[q];
                        work_in[2*q + 1] = rnd_s[q + 8];
                     end
                  end else begin
                     work_in = rnd_s;
                  end
                  // advance the schedule window
                  for (int j = 0; j < 15; j++) begin
                     blk_in[j] = blk_ff[j + 1];
                  end
                  blk_in[15] = wv_ff;
                  step_in    = '0;
                  round_in   = round_ff + 6'd1;
                  if (round_ff == LAST_ROUND) begin
                     state_in = ST_CMP_ADD;
                  end
               end
               default: ;
            endcase
         end
         ST_CMP_ADD: begin
            for (int j = 0; j < 16; j++) begin
               chain_in[j] = chain_ff[j] + work_ff[j];
            end
            step_in  = '0;
            qc_in    = '0;
            state_in = ret_ff;
         end
         ST_FOLD: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd1) begin
               acc_in = fold_x + rotr(fold_x, {2'b00, qc_ff} + 5'd1);
            end
            if (step_ff == 4'd4) begin
               fw_in[qc_ff] = acc_ff + mr_ff[0] + mr_ff[1] + mr_ff[2];
               for (int j = 0; j < 15; j++) begin
                  chain_in[j] = chain_ff[j + 1];
               end
               step_in = '0;
               qc_in   = qc_ff + 3'd1;
               if (qc_ff == 3'd7) begin
                  mix_rnd_in = '0;
                  state_in   = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd1) begin
               acc_in = fw_ff[0] + rotr(fw_ff[3], 5'd7) + rotr(fw_ff[7], 5'd21);
            end
            if (step_ff == 4'd3) begin
               nf_in[qc_ff] = acc_ff + mr_ff[0] + mr_ff[1];
               for (int j = 0; j < 8; j++) begin
                  fw_in[j] = fw_ff[(j + 1) % 8];
               end
               step_in = '0;
               qc_in   = qc_ff + 3'd1;
               if (qc_ff == 3'd7) begin
                  state_in = ST_MIX_COMMIT;
               end
            end
         end
         ST_MIX_COMMIT: begin
            fw_in      = nf_ff;
            mix_rnd_in = mix_rnd_ff + 2'd1;
            step_in    = '0;
            qc_in      = '0;
            if (mix_rnd_ff == 2'd2) begin
               out_idx_in = '0;
               state_in   = ST_OUT;
            end else begin
               state_in = ST_MIX;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               for (int j = 0; j < 8; j++) begin
                  fw_in[j] = fw_ff[(j + 1) % 8];
               end
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  // back to a fresh message
                  for (int j = 0; j < 16; j++) begin
                     chain_in[j] = iv_word(4'(j));
                  end
                  len_in   = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // byte into the block buffer; a full block goes to compression
      if (push_en) begin
         unique case (fill_ff[1:0])
            2'd0: blk_in[fill_ff[5:2]][31:24] = push_byte;
            2'd1: blk_in[fill_ff[5:2]][23:16] = push_byte;
            2'd2: blk_in[fill_ff[5:2]][15:8]  = push_byte;
            2'd3: blk_in[fill_ff[5:2]][7:0]   = push_byte;
         endcase
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            ret_in   = after_st;
            state_in = ST_CMP_LOAD;
         end else begin
            state_in = after_st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         fill_ff    <= '0;
         len_ff     <= '0;
         step_ff    <= '0;
         round_ff   <= '0;
         qc_ff      <= '0;
         mix_rnd_ff <= '0;
         rem_ff     <= '0;
         last_ff    <= 1'b0;
         lc_ff      <= '0;
         out_idx_ff <= '0;
         for (int j = 0; j < 16; j++) begin
            chain_ff[j] <= iv_word(4'(j));
         end
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         step_ff    <= step_in;
         round_ff   <= round_in;
         qc_ff      <= qc_in;
         mix_rnd_ff <= mix_rnd_in;
         rem_ff     <= rem_in;
         last_ff    <= last_in;
         lc_ff      <= lc_in;
         out_idx_ff <= out_idx_in;
         chain_ff   <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      blk_ff  <= blk_in;
      fw_ff   <= fw_in;
      nf_ff   <= nf_in;
      mr_ff   <= mr_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      t4_ff   <= t4_in;
      acc_ff  <= acc_in;
      wv_ff   <= wv_in;
      y0_ff   <= y0_in;
      data_ff <= data_in;
   end

endmodule

>>> design/wmh_checker.sv
// Checker on the hash engine ports, bound to the top level.
`include "wide_multiply_hash256_engine_macros.svh"

module wmh_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic       rsp_last_result
);

   // busy from input accept until the digest is out; digest words step through their index up to the last
   `WMH_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `WMH_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `WMH_ASSERT_NOW(a_last_on_eighth, clock, reset, rsp_valid, rsp_last_result == (rsp_word_index == 3'd7))
   `WMH_ASSERT_NEXT(a_index_steps, clock, reset, rsp_valid && rsp_ready && !rsp_last_result, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
   `WMH_ASSERT_NEXT(a_done_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last_result, !rsp_valid)

endmodule

bind wide_multiply_hash256_engine wmh_checker u_wmh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_word_index  (rsp_chan.word_index),
   .rsp_last_result (rsp_chan.last_result)
);

>>> tb/sv/tb_wide_multiply_hash256_engine.sv
// Testbench: random and directed message streams checked against a digest predictor.
`timescale 1ns / 100ps

module tb_wide_multiply_hash256_engine;
   import wmh_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int TAIL_CYCLES = 400;

   typedef struct {
      word_type   data_word;
      logic [2:0] valid_bytes;
      logic       last_word;
      logic       wait_drain;
   } msg_word_t;

   typedef struct {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_result;
   } digest_word_t;

   logic clock;
   logic reset;

   wmh_req_if req_bus ();
   wmh_rsp_if rsp_bus ();

   wide_multiply_hash256_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   msg_word_t    pending_words[$];
   digest_word_t digest_fifo[$];
   int           error_count = 0;
   int           cycle_count = 0;

   // predictor state
   word_type     hash_chain[16];
   word_type     msg_block[16];
   int unsigned  fill_cnt;
   logic [63:0]  msg_bits;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic word_type rot_r(word_type x, int unsigned n);
      n = n & 31;
      if (n == 0) return x;
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type rot_l(word_type x, int unsigned n);
      return rot_r(x, (32 - (n & 31)) & 31);
   endfunction

   function automatic word_type mul_fold(word_type a, word_type b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[63:32] ^ p[31:0];
   endfunction

   function automatic word_type sig_b0(word_type x);
      return rot_r(x, 2) ^ rot_r(x, 13) ^ rot_r(x, 22);
   endfunction
   function automatic word_type sig_b1(word_type x);
      return rot_r(x, 6) ^ rot_r(x, 11) ^ rot_r(x, 25);
   endfunction
   function automatic word_type sig_s0(word_type x);
      return rot_r(x, 7) ^ rot_r(x, 18) ^ (x >> 3);
   endfunction
   function automatic word_type sig_s1(word_type x);
      return rot_r(x, 17) ^ rot_r(x, 19) ^ (x >> 10);
   endfunction
   function automatic word_type ch_f(word_type x, word_type y, word_type z);
      return (x & y) ^ (~x & z);
   endfunction
   function automatic word_type maj_f(word_type x, word_type y, word_type z);
      return (x & y) ^ (x & z) ^ (y & z);
   endfunction

   function automatic word_type key_of(int unsigned r);
      word_type k [52] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
         32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
         32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
         32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
         32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
         32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
         32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
         32'h2748774c, 32'h34b0bcb5};
      return k[r];
   endfunction

   function automatic void restart_message();
      word_type iv [16] = '{
         32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19,
         32'hcbbb9d5d, 32'h629a292a, 32'h9159015a, 32'h152fecd8,
         32'h67332667, 32'h8eb44a87, 32'hdb0c2e0d, 32'h47b5481d};
      hash_chain = iv;
      foreach (msg_block[q]) msg_block[q] = '0;
      fill_cnt = 0;
      msg_bits = '0;
   endfunction

   function automatic void compress_block();
      word_type w[16];
      word_type s[16];
      word_type t[16];
      word_type wv, kv, t1, t2, t3, t4;
      word_type m1, m2, m3, m4, m5, m6, m7, m8, m9, m10;
      w = msg_block;
      s = hash_chain;
      for (int unsigned r = 0; r < 52; r++) begin
         if (r < 16) begin
            wv = w[r];
         end else begin
            wv = sig_s1(w[(r-2)&15]) + w[(r-7)&15] + sig_s0(w[(r-15)&15]) + w[(r-16)&15]
               + mul_fold(w[(r-3)&15], w[(r-10)&15])
               + (mul_fold(w[(r-5)&15], w[(r-12)&15])
                  ^ mul_fold(w[(r-1)&15] ^ w[(r-8)&15], w[(r-4)&15] ^ w[(r-14)&15]));
            w[r&15] = wv;
         end
         kv = key_of(r);
         t1 = s[7] + sig_b1(s[4]) + ch_f(s[4], s[5], s[6]) + kv + wv;
         t2 = sig_b0(s[0]) + maj_f(s[0], s[1], s[2]);
         m1 = mul_fold(s[0] ^ s[8], s[4] ^ s[12]);
         m2 = mul_fold(s[1] ^ s[9], s[5] ^ s[13]);
         m3 = mul_fold(s[2] ^ s[10], s[6] ^ s[14]);
         m4 = mul_fold(s[3] ^ s[11], s[7] ^ s[15]);
         m5 = mul_fold(s[0] ^ s[12], s[4] ^ s[8]);
         m6 = mul_fold(s[1] ^ s[13], s[5] ^ s[9]);
         m7 = mul_fold(s[2] ^ s[14], s[6] ^ s[10]);
         m8 = mul_fold(s[3] ^ s[15], s[7] ^ s[11]);
         m9 = mul_fold(s[0] ^ s[15], s[3] ^ s[12]);
         m10 = mul_fold(s[1] ^ s[14], s[2] ^ s[13]);
         t3 = s[15] + sig_b1(s[12]) + ch_f(s[12], s[13], s[14]) + (kv ^ LOWER_KEY_MASK) + wv;
         t4 = sig_b0(s[8]) + maj_f(s[8], s[9], s[10]);
         t[0] = t1 + t2 + m1 + m5 + m9;
         t[1] = s[0] + m6 + m10;
         t[2] = s[1];
         t[3] = s[2] + m2 + m7;
         t[4] = s[3] + t1 + m9;
         t[5] = s[4] + m8;
         t[6] = s[5];
         t[7] = s[6] + m3 + m10;
         t[8] = t3 + t4 + m1 + m5;
         t[9] = s[8] + m6;
         t[10] = s[9];
         t[11] = s[10] + m4 + m7;
         t[12] = s[11] + t3 + m9;
         t[13] = s[12] + m8;
         t[14] = s[13];
         t[15] = s[14] + (m2 ^ m3 ^ m4) + m10;
         s = t;
         // interleave upper and lower halves every fourth round
         if ((r & 3) == 3) begin
            for (int q = 0; q < 8; q++) begin
               s[2*q] = t[q];
               s[2*q+1] = t[q+8];
            end
         end
      end
      for (int q = 0; q < 16; q++) hash_chain[q] += s[q];
   endfunction

   function automatic void add_byte(logic [7:0] b);
      int unsigned wi, sh;
      wi = (fill_cnt >> 2) & 15;
      sh = 24 - 8 * (fill_cnt & 3);
      msg_block[wi] = (msg_block[wi] & ~(32'hFF << sh)) | (word_type'(b) << sh);
      fill_cnt++;
      if (fill_cnt >= 64) begin
         compress_block();
         fill_cnt = 0;
      end
   endfunction

   function automatic void predict_digest(msg_word_t it);
      int unsigned nb;
      logic [63:0] bits;
      word_type fw[8];
      word_type nf[8];
      word_type u, lo;
      digest_word_t d;
      nb = (it.valid_bytes > 4) ? 4 : it.valid_bytes;
      for (int unsigned q = 0; q < nb; q++) add_byte(8'(it.data_word >> (24 - 8 * q)));
      msg_bits += 64'(nb * 8);
      if (!it.last_word) return;
      bits = msg_bits;
      add_byte(PAD_MARK_BYTE);
      while (fill_cnt != 56) add_byte(8'h00);
      for (int unsigned q = 0; q < 8; q++) add_byte(8'(bits >> (56 - 8 * q)));
      for (int unsigned q = 0; q < 8; q++) begin
         u = hash_chain[q];
         lo = hash_chain[q+8];
         fw[q] = (u ^ lo) + mul_fold(u, rot_l(lo, 13)) + mul_fold(lo, rot_r(u, 7))
               + mul_fold(u ^ lo, rot_r(u, 3) ^ rot_l(lo, 11)) + rot_r(u ^ lo, q + 1);
      end
      repeat (3) begin
         for (int unsigned q = 0; q < 8; q++)
            nf[q] = fw[q] + mul_fold(fw[(q+1)&7], fw[(q+5)&7])
                  + mul_fold(fw[(q+2)&7], fw[(q+6)&7])
                  + rot_r(fw[(q+3)&7], 7) + rot_l(fw[(q+7)&7], 11);
         fw = nf;
      end
      for (int unsigned q = 0; q < 8; q++) begin
         d.digest_word = fw[q];
         d.word_index = 3'(q);
         d.last_result = (q == 7);
         digest_fifo.push_back(d);
      end
      restart_message();
   endfunction

   function automatic void queue_word(word_type d, int vb, bit last, bit hold = 0);
      msg_word_t it;
      it.data_word = d;
      it.valid_bytes = 3'(vb);
      it.last_word = last;
      it.wait_drain = hold;
      pending_words.push_back(it);
   endfunction

   // sender: one word per handshake, random gap drawn per word
   int  send_gap;
   bit  send_quiet;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
         send_quiet <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_digest(pending_words.pop_front());
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() > 0 &&
                         (!pending_words[0].wait_drain || digest_fifo.size() == 0)) begin
               req_bus.valid <= 1'b1;
               req_bus.data_word <= pending_words[0].data_word;
               req_bus.valid_bytes <= pending_words[0].valid_bytes;
               req_bus.last_word <= pending_words[0].last_word;
               if ($urandom_range(0, 19) == 0) send_quiet <= !send_quiet;
               send_gap <= send_quiet ? 0 : $urandom_range(0, 13);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall drawn per digest word, compare against oldest prediction
   int  recv_stall;
   bit  recv_quiet;
   always @(posedge clock) begin
      int c;
      digest_word_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
         recv_quiet <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (digest_fifo.size() == 0) begin
            $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                     rsp_bus.digest_word, rsp_bus.word_index, rsp_bus.last_result);
            error_count++;
         end else begin
            want = digest_fifo.pop_front();
            if (rsp_bus.digest_word !== want.digest_word ||
                rsp_bus.word_index !== want.word_index ||
                rsp_bus.last_result !== want.last_result) begin
               $display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                        want.digest_word, want.word_index, want.last_result,
                        rsp_bus.digest_word, rsp_bus.word_index, rsp_bus.last_result);
               error_count++;
            end
         end
         if ($urandom_range(0, 19) == 0) recv_quiet <= !recv_quiet;
         c = recv_quiet ? 0 : $urandom_range(0, 13);
         rsp_bus.ready <= (c == 0);
         recv_stall <= (c > 0) ? c - 1 : 0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int n, total;
      req_bus.valid = 1'b0;
      req_bus.data_word = '0;
      req_bus.valid_bytes = '0;
      req_bus.last_word = 1'b0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;
      restart_message();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty message, then oversized count on a final word
      queue_word(32'h0000_0000, 0, 1);
      queue_word(32'hFFFF_FFFF, 7, 1);
      // partial and empty words inside a message, ignored low bytes
      queue_word(32'hFFFF_FFFF, 4, 0);
      queue_word(32'hA5FF_FFFF, 1, 0);
      queue_word(32'h1234_5678, 0, 0);
      queue_word(32'h8000_0001, 5, 0);
      queue_word(32'hC3C3_0000, 2, 1);
      // 56 bytes: padding spills into a second block; wait for drain first
      for (int q = 0; q < 14; q++) queue_word($urandom, 4, q == 13, q == 0);
      queue_word(32'h0000_0000, 6, 1);
      total = pending_words.size();

      while (total < 160) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 18);
         for (int q = 0; q < n; q++) begin
            if ($urandom_range(0, 6) == 0) queue_word($urandom, $urandom_range(0, 7), 0);
            else queue_word($urandom, 4, 0);
         end
         queue_word($urandom, $urandom_range(0, 7), 1, $urandom_range(0, 9) == 0);
         total += n + 1;
      end

      while (pending_words.size() > 0 || req_bus.valid) @(posedge clock);
      while (digest_fifo.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && digest_fifo.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> wide_multiply_hash256_engine.f
+incdir+design
design/wmh_pkg.sv
design/wmh_chan_if.sv
design/wmh_mix_unit.sv
design/wide_multiply_hash256_engine.sv
design/wmh_checker.sv
tb/sv/tb_wide_multiply_hash256_engine.sv
